// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/sha256_pkg.sv =====
// Package with SHA-256 types, constants and round functions.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // Request from the sequencer to the round unit.
  typedef struct packed {
    logic start;
    logic reset_h;
  } rnd_ctl_t;

  localparam int unsigned ROUNDS = 64;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha256_round.sv =====
// Shared SHA-256 round unit: message schedule window and working variables.
module sha256_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::rnd_ctl_t  ctl,
  input  logic                  load_w,
  input  logic [31:0]           load_word,
  input  logic                  step,
  input  logic [5:0]            round_idx,
  input  logic                  add_h,
  output logic [31:0]           h_out [8]
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [31:0] w_new, t1, t2, s0, s1, b0, b1, ch, mj;

  always_comb begin
    s0 = sha256_pkg::rotr(w_r[1], 7) ^ sha256_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha256_pkg::rotr(w_r[14], 17) ^ sha256_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    b1 = sha256_pkg::rotr(v_r[4], 6) ^ sha256_pkg::rotr(v_r[4], 11)
       ^ sha256_pkg::rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + b1 + ch + sha256_pkg::ROUND_K[round_idx] + w_r[0];
    b0 = sha256_pkg::rotr(v_r[0], 2) ^ sha256_pkg::rotr(v_r[0], 13)
       ^ sha256_pkg::rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = b0 + mj;
  end

  // The window w_r[0] always holds the current round's schedule word.
  always_ff @(posedge clk) begin
    if (load_w) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= load_word;
    end else if (step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.reset_h) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::INIT_H[i];
    end else if (add_h) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign h_out = h_r;

endmodule

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// Top level of the streaming SHA-256 hasher: byte packing, padding and sequencing.
// Usage: present one word per input handshake on in_data (data_byte, has_byte,
// end_of_message). A byte is packed into a 32-bit word; each full word shifts
// into the schedule window. After 64 bytes the shared round unit runs 64 rounds,
// one per cycle, then folds the result into the chaining state.
// An input byte that does not fill a block is taken without a stall; a block-closing
// byte holds off further input until the rounds and the fold are done.
// End of message inserts the 0x80 byte, zero fill and the 64-bit bit length one
// byte per cycle between compressions, runs one or two compressions, then offers
// the eight digest words H0..H7 on out_data, one per handshake, last_word on H7.
// in_ready stays low while rounds, padding or digest output are in progress.
// A stalled receiver holds the current digest word; nothing is lost.
// After the last digest word the chaining state and counters return to their
// initial values. Reset (rst_n low, synchronous) does the same and empties out.
module sha256_stream_hasher_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sha256_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sha256_pkg::out_item_t  out_data
);

  sha256_pkg::state_t state_r, state_nxt;
  logic [5:0]  fill_r;
  logic [60:0] bytes_r;
  logic [23:0] part_r;
  logic [5:0]  rnd_r;
  logic        pad_r;     // padding in progress
  logic        pad80_r;   // 0x80 byte already appended
  logic        final_r;   // current compression is the last of the message
  logic [2:0]  oidx_r;
  logic [31:0] h [8];

  sha256_pkg::rnd_ctl_t ctl;
  logic        acc, pbyte_en, load_w, step, add_h;
  logic [7:0]  pbyte;
  logic [63:0] bitlen;
  logic [31:0] load_word;
  logic        blk_full;

  assign acc    = in_valid && in_ready;
  assign bitlen = {bytes_r, 3'b000};

  // Byte fed to the packer this cycle: input byte or padding byte.
  always_comb begin
    pbyte_en = 1'b0;
    pbyte    = in_data.data_byte;
    if (state_r == sha256_pkg::ST_IDLE && pad_r) begin
      pbyte_en = 1'b1;
      if (!pad80_r) pbyte = sha256_pkg::PAD_BYTE;
      else if (fill_r >= 6'(sha256_pkg::LEN_POS) && final_r)
        pbyte = bitlen[{~fill_r[2:0], 3'b000} +: 8];
      else pbyte = 8'h00;
    end else if (acc && in_data.has_byte) begin
      pbyte_en = 1'b1;
    end
  end

  assign load_word = {part_r, pbyte};
  assign load_w    = pbyte_en && (fill_r[1:0] == 2'b11);
  assign blk_full  = pbyte_en && (fill_r == 6'd63);
  assign step      = (state_r == sha256_pkg::ST_ROUND);
  assign add_h     = (state_r == sha256_pkg::ST_ADD);
  assign ctl.start   = blk_full;
  assign ctl.reset_h = out_valid && out_ready && oidx_r == 3'd7;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (blk_full) state_nxt = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd_r == 6'(sha256_pkg::ROUNDS - 1)) state_nxt = sha256_pkg::ST_ADD;
      end
      sha256_pkg::ST_ADD: begin
        state_nxt = (final_r && pad_r) ? sha256_pkg::ST_OUT : sha256_pkg::ST_IDLE;
      end
      sha256_pkg::ST_OUT: begin
        if (ctl.reset_h) state_nxt = sha256_pkg::ST_IDLE;
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == sha256_pkg::ST_IDLE) && !pad_r;
    out_valid = (state_r == sha256_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256_pkg::ST_IDLE;
      fill_r  <= '0;
      bytes_r <= '0;
      rnd_r   <= '0;
      pad_r   <= 1'b0;
      pad80_r <= 1'b0;
      final_r <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (pbyte_en) begin
        fill_r <= fill_r + 6'd1;
        if (pad_r && !pad80_r) begin
          pad80_r <= 1'b1;
          // Length fits in this block if the 0x80 byte lands before offset 56.
          final_r <= (fill_r < 6'(sha256_pkg::LEN_POS));
        end
      end
      // A padding block without the length is followed by the final block.
      if (add_h && pad_r && pad80_r) final_r <= 1'b1;
      if (acc && in_data.has_byte) bytes_r <= bytes_r + 61'd1;
      if (acc && in_data.end_of_message) pad_r <= 1'b1;
      if (step) rnd_r <= rnd_r + 6'd1;
      if (out_valid && out_ready) oidx_r <= oidx_r + 3'd1;
      if (ctl.reset_h) begin
        fill_r  <= '0;
        bytes_r <= '0;
        pad_r   <= 1'b0;
        pad80_r <= 1'b0;
        final_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pbyte_en) part_r <= {part_r[15:0], pbyte};
  end

  sha256_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load_w    (load_w),
    .load_word (load_word),
    .step      (step),
    .round_idx (rnd_r),
    .add_h     (add_h),
    .h_out     (h)
  );

  always_comb begin
    out_data.digest_word = h[oidx_r];
    out_data.word_index  = oidx_r;
    out_data.last_word   = (oidx_r == 3'd7);
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_out_excl, clk, rst_n, out_valid, !in_ready)
  `ASSERT_IMPL(a_round_idx, clk, rst_n, state_r == sha256_pkg::ST_ADD, rnd_r == 6'd0)
  `ASSERT_NEXT(a_last_wraps, clk, rst_n, ctl.reset_h, oidx_r == 3'd0 && fill_r == 6'd0)

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the streaming SHA-256 hasher: random byte streams checked against a digest model.
`timescale 1ns / 100ps
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sha256_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sha256_pkg::out_item_t out_data;

  sha256_stream_hasher_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Model of the hasher state.
  logic [31:0] chain_h [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [60:0] msg_len;

  sha256_pkg::in_item_t  pending_words [$];
  sha256_pkg::out_item_t digest_queue [$];
  int unsigned error_count = 0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, x, y;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-7]
           + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = sha256_pkg::INIT_H[i];
    for (int i = 0; i < 64; i++) msg_block[i] = '0;
    block_fill = 0;
    msg_len = '0;
  endtask

  task automatic put_bit_length(input logic [63:0] bits);
    for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
  endtask

  task automatic enqueue_word(input sha256_pkg::in_item_t it);
    pending_words.insert(pending_words.size(), it);
  endtask

  task automatic predict_digest(input sha256_pkg::in_item_t it);
    logic [63:0] bits;
    sha256_pkg::out_item_t r;
    if (it.has_byte) begin
      msg_block[block_fill] = it.data_byte;
      block_fill++;
      msg_len = msg_len + 1'b1;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (it.end_of_message) begin
      bits = {msg_len, 3'b000};
      msg_block[block_fill] = sha256_pkg::PAD_BYTE;
      for (int i = block_fill + 1; i < 64; i++) msg_block[i] = '0;
      if (block_fill < sha256_pkg::LEN_POS) begin
        put_bit_length(bits);
        compress_block();
      end else begin
        compress_block();
        for (int i = 0; i < 64; i++) msg_block[i] = '0;
        put_bit_length(bits);
        compress_block();
      end
      for (int i = 0; i < 8; i++) begin
        r.digest_word = chain_h[i];
        r.word_index = 3'(i);
        r.last_word = (i == 7);
        digest_queue.insert(digest_queue.size(), r);
      end
      clear_hash();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Returns once nothing is pending, in flight or expected; sampled away from the edge.
  task automatic wait_drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || digest_queue.size() != 0);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sha256_pkg::in_item_t make_word(input bit has, input bit eom);
    sha256_pkg::in_item_t it;
    it.data_byte = 8'($urandom);
    it.has_byte = has;
    it.end_of_message = eom;
    return it;
  endfunction

  // Queues a whole message of n bytes; idle words are sprinkled in.
  task automatic add_message(input int n, input bit last_has_byte);
    for (int i = 0; i < n - (last_has_byte ? 1 : 0); i++) begin
      if ($urandom_range(0, 9) == 0) enqueue_word(make_word(1'b0, 1'b0));
      enqueue_word(make_word(1'b1, 1'b0));
    end
    enqueue_word(make_word(last_has_byte, 1'b1));
  endtask

  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_digest(in_data);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
          in_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("digest word with nothing expected");
        end else begin
          sha256_pkg::out_item_t exp_w;
          exp_w = digest_queue.pop_front();
          if (out_data.digest_word !== exp_w.digest_word)
            report_mismatch($sformatf("digest_word %h, expected %h",
                                      out_data.digest_word, exp_w.digest_word));
          if (out_data.word_index !== exp_w.word_index)
            report_mismatch($sformatf("word_index %0d, expected %0d",
                                      out_data.word_index, exp_w.word_index));
          if (out_data.last_word !== exp_w.last_word)
            report_mismatch($sformatf("last_word %b, expected %b",
                                      out_data.last_word, exp_w.last_word));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
      end
    end
  end

  initial begin
    clear_hash();
    // Directed messages: empty, one byte, idle words and a short message.
    enqueue_word(make_word(1'b0, 1'b1));
    enqueue_word('{data_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b1});
    enqueue_word('{data_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b0});
    enqueue_word('{data_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b0});
    enqueue_word('{data_byte: 8'h5a, has_byte: 1'b0, end_of_message: 1'b1});
    add_message(3, 1'b1);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // The sender stays idle until every digest of the first batch is in.
    wait_drain();
    // One full block mid-message, then the 0x80 byte at offset 56: two final blocks.
    add_message(120, 1'b1);
    wait_drain();
    repeat (300) @(posedge clk);
    if (error_count == 0 && digest_queue.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
